[sv/cbeq_pkg.sv]
// Shared package for the cascaded biquad equalizer.
// Holds constants, command/op/state enums and the slot mapping.
// No dependencies.
package cbeq_pkg;

  localparam int NUM_BANDS_DEF    = 10;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 32;

  localparam int DIG_W     = 8;   // multiplier digit per cycle
  localparam int DELAY_W   = 48;  // delay word width
  localparam int EN_W      = 10;  // band_enable width
  localparam int NUM_SLOTS = 5;   // coefficients per band

  typedef enum logic [1:0] {
    CMD_FILTER = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_t;

  // order of products within one band
  typedef enum logic [2:0] {
    OP_B0 = 3'd0,
    OP_B1 = 3'd1,
    OP_A1 = 3'd2,
    OP_B2 = 3'd3,
    OP_A2 = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAND,
    ST_RD,
    ST_LD,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_DONE
  } state_t;

  function automatic slot_t op_slot(op_t op);
    slot_t s;
    s = SLOT_B0;
    unique case (op)
      OP_B0:   s = SLOT_B0;
      OP_B1:   s = SLOT_B1;
      OP_A1:   s = SLOT_A1;
      OP_B2:   s = SLOT_B2;
      OP_A2:   s = SLOT_A2;
      default: s = SLOT_B0;
    endcase
    return s;
  endfunction

endpackage

[sv/cbeq_ram.sv]
// Single-write, single-read memory with registered read and per-entry valid bits.
// Unwritten or cleared entries report valid low. Uses no package.
module cbeq_ram #(
  parameter int DEPTH = 8,
  parameter int W     = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic                     clr,
  output logic [W-1:0]             rdata,
  output logic                     rvld
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rdata_r;
  assign rvld  = rvld_r;

endmodule

[sv/cbeq_mac.sv]
// Digit-serial multiplier: operand times coefficient, one 8-bit digit per cycle,
// most significant digit first (Horner). Depends on cbeq_pkg.
module cbeq_mac #(
  parameter int SIG_W  = 20,
  parameter int COEF_W = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic signed [SIG_W-1:0]  opnd,
  input  logic signed [COEF_W-1:0] coef,
  output logic signed [SIG_W+((COEF_W+cbeq_pkg::DIG_W-1)/cbeq_pkg::DIG_W)*cbeq_pkg::DIG_W-1:0]
                                   prod,
  output logic                     done
);

  localparam int DIG  = cbeq_pkg::DIG_W;
  localparam int NDIG = (COEF_W + DIG - 1) / DIG;
  localparam int EXT  = NDIG * DIG;
  localparam int PW   = SIG_W + EXT;
  localparam int CW   = $clog2(NDIG);

  logic signed [SIG_W-1:0]     opnd_r;
  logic [EXT-1:0]              coef_sr_r;
  logic signed [PW-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r, done_r;
  logic [DIG-1:0]              digit;
  logic signed [DIG:0]         dsgn;
  logic signed [SIG_W+DIG:0]   pp;

  always_comb begin
    digit   = coef_sr_r[EXT-1 -: DIG];
    // top digit carries the sign, the rest are unsigned
    dsgn    = (cnt_r == '0) ? $signed({digit[DIG-1], digit}) : $signed({1'b0, digit});
    pp      = opnd_r * dsgn;
    acc_nxt = (acc_r <<< DIG) + PW'(pp);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      opnd_r    <= opnd;
      coef_sr_r <= EXT'(coef);
      acc_r     <= '0;
    end else if (busy_r) begin
      coef_sr_r <= coef_sr_r << DIG;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NDIG - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

[sv/cascaded_biquad_equalizer.sv]
// Ten-band cascaded biquad equalizer, transposed direct form II, fixed point.
// Depends on cbeq_pkg, cbeq_ram (coefficient and delay stores), cbeq_mac.
//
// Usage:
//  - Input words on in_*: in_tuser is the command (filter, write coefficient,
//    clear delay state), in_tlast marks the last sample of a buffer.
//  - A filter word yields one output word on out_*; the others yield none.
//  - cfg_* writes band_enable; write it only while the block is idle.
// Timing:
//  - Coefficient write and delay clear do not hold the input (in_tready stays high).
//  - A sample runs every enabled band on one shared digit-serial multiplier:
//    five products, each read, loaded, multiplied digit by digit and
//    accumulated, plus three finish steps and one band-select step per
//    enabled band; a bypassed band takes only its band-select step, and a
//    done step ends the sample. The multiplier and one read port per store set this pace.
//  - One sample at a time: in_tready is low while a sample is in flight.
// Reset: coefficients read as pass-through (b0 = 1), delay words as zero,
//  band_enable all ones, output empty.
// Stall: the result waits in the output register; the next word is taken
//  meanwhile, and a later result waits until the register is free.
module cascaded_biquad_equalizer #(
  parameter int NUM_BANDS    = cbeq_pkg::NUM_BANDS_DEF,
  parameter int SAMPLE_WIDTH = cbeq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = cbeq_pkg::COEF_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // input stream
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: sample_in, band_index(4), coef_index(3), coef_value, zero pad
  input  logic [((SAMPLE_WIDTH+7+COEF_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic [1:0] in_tuser,   // command
  input  logic in_tlast,         // end_of_block
  // result stream
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: sample_out, zero pad
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,        // block_end
  // band_enable write
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [cbeq_pkg::EN_W-1:0] cfg_data
);

  localparam int DIG   = cbeq_pkg::DIG_W;
  localparam int DW    = cbeq_pkg::DELAY_W;
  localparam int ENW   = cbeq_pkg::EN_W;
  localparam int SIG_W = SAMPLE_WIDTH + 4;
  localparam int CF    = COEF_WIDTH - 4;
  localparam int NDIG  = (COEF_WIDTH + DIG - 1) / DIG;
  localparam int PW    = SIG_W + NDIG * DIG;
  localparam int SW    = ((PW > DW) ? PW : DW) + 2;
  localparam int BW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CDEP  = NUM_BANDS * cbeq_pkg::NUM_SLOTS;
  localparam int DDEP  = NUM_BANDS * 2;
  localparam int CAW   = $clog2(CDEP);
  localparam int DAW   = $clog2(DDEP);
  localparam int ODW   = ((SAMPLE_WIDTH + 7) / 8) * 8;

  localparam logic signed [SW-1:0] HALF  = SW'(65'sd1 <<< (CF - 1));
  localparam logic signed [SW-1:0] Y_MAX = SW'((65'sd1 <<< (SIG_W - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] Y_MIN = -Y_MAX - SW'(1);
  localparam logic signed [SW-1:0] D_MAX = SW'((65'sd1 <<< (DW - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] D_MIN = -D_MAX - SW'(1);
  localparam logic signed [SIG_W-1:0] O_MAX =
    SIG_W'((65'sd1 <<< (SAMPLE_WIDTH - 1)) - 65'sd1);
  localparam logic signed [SIG_W-1:0] O_MIN = -O_MAX - SIG_W'(1);
  localparam logic signed [COEF_WIDTH-1:0] C_ONE = COEF_WIDTH'(65'sd1 <<< CF);

  // input fields
  logic signed [SAMPLE_WIDTH-1:0] f_sample;
  logic [3:0]                     f_band;
  logic [2:0]                     f_slot;
  logic signed [COEF_WIDTH-1:0]   f_coef;
  cbeq_pkg::cmd_t                 f_cmd;

  assign f_sample = in_tdata[SAMPLE_WIDTH-1:0];
  assign f_band   = in_tdata[SAMPLE_WIDTH+3 -: 4];
  assign f_slot   = in_tdata[SAMPLE_WIDTH+6 -: 3];
  assign f_coef   = in_tdata[SAMPLE_WIDTH+7 +: COEF_WIDTH];
  assign f_cmd    = cbeq_pkg::cmd_t'(in_tuser);

  cbeq_pkg::state_t state_r, state_nxt;
  cbeq_pkg::op_t    op_r, op_nxt;
  logic [BW-1:0]    band_r, band_nxt;
  logic [ENW-1:0]   en_r;
  logic signed [SIG_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [SW-1:0]    sum_r, sum_nxt;
  logic             eob_r, eob_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic in_acc, band_on, band_last, out_free, is_y_op;

  // memories and multiplier
  logic                         c_we, c_re, d_we, d_re, d_clr, c_vld, d_vld;
  logic [CAW-1:0]               c_waddr, c_raddr;
  logic [DAW-1:0]               d_waddr, d_raddr;
  logic [COEF_WIDTH-1:0]        c_dout;
  logic [DW-1:0]                d_dout, d_wdata;
  logic signed [COEF_WIDTH-1:0] c_eff;
  logic signed [DW-1:0]         z_eff;
  logic                         m_load, m_done;
  logic signed [PW-1:0]         m_prod;
  logic signed [SIG_W-1:0]      m_opnd;

  logic signed [SW-1:0] v_y, sh_y, y_sat, v_z1, z1_sat, z2_sat;
  logic signed [SIG_W-1:0] o_sat;

  assign in_tready = (state_r == cbeq_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign band_on   = (32'(band_r) < ENW) && (|(en_r & (ENW'(1) << band_r)));
  assign band_last = (band_r == BW'(NUM_BANDS - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign is_y_op   = (op_r == cbeq_pkg::OP_A1) || (op_r == cbeq_pkg::OP_A2);

  cbeq_ram #(.DEPTH(CDEP), .W(COEF_WIDTH)) u_coef (
    .clk(clk), .rst_n(rst_n),
    .we(c_we), .waddr(c_waddr), .wdata(f_coef),
    .re(c_re), .raddr(c_raddr), .clr(1'b0),
    .rdata(c_dout), .rvld(c_vld)
  );

  cbeq_ram #(.DEPTH(DDEP), .W(DW)) u_delay (
    .clk(clk), .rst_n(rst_n),
    .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .clr(d_clr),
    .rdata(d_dout), .rvld(d_vld)
  );

  cbeq_mac #(.SIG_W(SIG_W), .COEF_W(COEF_WIDTH)) u_mac (
    .clk(clk), .rst_n(rst_n), .load(m_load),
    .opnd(m_opnd), .coef(c_eff), .prod(m_prod), .done(m_done)
  );

  // unwritten coefficients read as pass-through, cleared delays as zero
  assign c_eff  = c_vld ? $signed(c_dout) :
                  ((op_r == cbeq_pkg::OP_B0) ? C_ONE : '0);
  assign z_eff  = d_vld ? $signed(d_dout) : '0;
  assign m_opnd = is_y_op ? y_r : x_r;

  // rounding and saturation
  always_comb begin
    v_y    = sum_r + SW'(z_eff) + HALF;
    sh_y   = v_y >>> CF;
    y_sat  = (sh_y > Y_MAX) ? Y_MAX : ((sh_y < Y_MIN) ? Y_MIN : sh_y);
    v_z1   = sum_r + SW'(z_eff);
    z1_sat = (v_z1 > D_MAX) ? D_MAX : ((v_z1 < D_MIN) ? D_MIN : v_z1);
    z2_sat = (sum_r > D_MAX) ? D_MAX : ((sum_r < D_MIN) ? D_MIN : sum_r);
    o_sat  = (x_r > O_MAX) ? O_MAX : ((x_r < O_MIN) ? O_MIN : x_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbeq_pkg::ST_IDLE:
        if (in_acc && f_cmd == cbeq_pkg::CMD_FILTER) state_nxt = cbeq_pkg::ST_BAND;
      cbeq_pkg::ST_BAND:
        if (band_on) state_nxt = cbeq_pkg::ST_RD;
        else if (band_last) state_nxt = cbeq_pkg::ST_DONE;
      cbeq_pkg::ST_RD:  state_nxt = cbeq_pkg::ST_LD;
      cbeq_pkg::ST_LD:  state_nxt = cbeq_pkg::ST_MUL;
      cbeq_pkg::ST_MUL:
        if (m_done) state_nxt = cbeq_pkg::ST_ACC;
      cbeq_pkg::ST_ACC:
        if (op_r == cbeq_pkg::OP_B1 || op_r == cbeq_pkg::OP_B2) state_nxt = cbeq_pkg::ST_RD;
        else state_nxt = cbeq_pkg::ST_FIN;
      cbeq_pkg::ST_FIN:
        if (op_r != cbeq_pkg::OP_A2) state_nxt = cbeq_pkg::ST_RD;
        else if (band_last) state_nxt = cbeq_pkg::ST_DONE;
        else state_nxt = cbeq_pkg::ST_BAND;
      cbeq_pkg::ST_DONE:
        if (out_free) state_nxt = cbeq_pkg::ST_IDLE;
      default: state_nxt = cbeq_pkg::ST_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    op_nxt         = op_r;
    band_nxt       = band_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    sum_nxt        = sum_r;
    eob_nxt        = eob_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    c_we    = 1'b0;
    c_waddr = CAW'(32'(f_band) * cbeq_pkg::NUM_SLOTS + 32'(f_slot));
    c_re    = 1'b0;
    c_raddr = CAW'(32'(band_r) * cbeq_pkg::NUM_SLOTS + 32'(cbeq_pkg::op_slot(op_r)));
    d_re    = 1'b0;
    d_raddr = DAW'(32'(band_r) * 2 + ((op_r == cbeq_pkg::OP_B0) ? 0 : 1));
    d_we    = 1'b0;
    d_waddr = DAW'(32'(band_r) * 2 + ((op_r == cbeq_pkg::OP_A1) ? 0 : 1));
    d_wdata = (op_r == cbeq_pkg::OP_A1) ? DW'(z1_sat) : DW'(z2_sat);
    d_clr   = 1'b0;
    m_load  = 1'b0;
    unique case (state_r)
      cbeq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (f_cmd)
            cbeq_pkg::CMD_FILTER: begin
              x_nxt    = SIG_W'(f_sample);
              eob_nxt  = in_tlast;
              band_nxt = '0;
            end
            cbeq_pkg::CMD_COEF:
              c_we = (32'(f_band) < NUM_BANDS) && (32'(f_slot) < cbeq_pkg::NUM_SLOTS);
            cbeq_pkg::CMD_CLEAR: d_clr = 1'b1;
            default: ;
          endcase
        end
      end
      cbeq_pkg::ST_BAND: begin
        op_nxt = cbeq_pkg::OP_B0;
        if (!band_on && !band_last) band_nxt = band_r + 1'b1;
      end
      cbeq_pkg::ST_RD: begin
        c_re = 1'b1;
        d_re = (op_r == cbeq_pkg::OP_B0) || (op_r == cbeq_pkg::OP_B1);
      end
      cbeq_pkg::ST_LD: m_load = 1'b1;
      cbeq_pkg::ST_MUL: ;
      cbeq_pkg::ST_ACC: begin
        sum_nxt = is_y_op ? (sum_r - SW'(m_prod)) : SW'(m_prod);
        if (op_r == cbeq_pkg::OP_B1) op_nxt = cbeq_pkg::OP_A1;
        if (op_r == cbeq_pkg::OP_B2) op_nxt = cbeq_pkg::OP_A2;
      end
      cbeq_pkg::ST_FIN: begin
        unique case (op_r)
          cbeq_pkg::OP_B0: begin
            y_nxt  = SIG_W'(y_sat);
            op_nxt = cbeq_pkg::OP_B1;
          end
          cbeq_pkg::OP_A1: begin
            d_we   = 1'b1;
            op_nxt = cbeq_pkg::OP_B2;
          end
          default: begin
            d_we  = 1'b1;
            x_nxt = y_r;
            if (!band_last) band_nxt = band_r + 1'b1;
          end
        endcase
      end
      cbeq_pkg::ST_DONE: begin
        if (out_free) begin
          out_sample_nxt = SAMPLE_WIDTH'(o_sat);
          out_last_nxt   = eob_r;
          out_valid_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbeq_pkg::ST_IDLE;
      op_r        <= cbeq_pkg::OP_B0;
      band_r      <= '0;
      en_r        <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      band_r      <= band_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    sum_r        <= sum_nxt;
    eob_r        <= eob_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'($unsigned(out_sample_r));
  assign out_tlast  = out_last_r;

endmodule

[dv/cascaded_biquad_equalizer_tb.sv]
// Testbench for cascaded_biquad_equalizer: drives commands and samples, predicts
// each equalized sample in fixed point and compares it on the output stream.
// Depends on cbeq_pkg and the equalizer RTL.
`timescale 1ns / 1ps

module cascaded_biquad_equalizer_tb;

  localparam int NB     = 10;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 16;
  localparam int COEF_FR = 28;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } eq_result_t;

  // ---------------------------------------------------------------------------
  // Equalizer scoreboard: own copy of coefficients, delay words and enables
  // ---------------------------------------------------------------------------
  class eq_scoreboard;
    longint coefs [NB][cbeq_pkg::NUM_SLOTS];
    longint delays[NB][2];
    logic [cbeq_pkg::EN_W-1:0] enables;
    eq_result_t pending[$];
    int errors;

    function void clear_all();
      for (int b = 0; b < NB; b++) begin
        for (int s = 0; s < cbeq_pkg::NUM_SLOTS; s++) coefs[b][s] = 0;
        coefs[b][cbeq_pkg::SLOT_B0] = longint'(1) <<< COEF_FR;
        delays[b][0] = 0;
        delays[b][1] = 0;
      end
      enables = '1;
      errors = 0;
    endfunction

    function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one TDF-II section; >>> on longint is an arithmetic (floor) shift
    function longint band_step(int b, longint x);
      longint acc, y, z1, z2;
      acc = x * coefs[b][cbeq_pkg::SLOT_B0] + delays[b][0];
      y = clamp((acc + (longint'(1) <<< (COEF_FR - 1))) >>> COEF_FR, 20);
      z1 = x * coefs[b][cbeq_pkg::SLOT_B1] - y * coefs[b][cbeq_pkg::SLOT_A1]
           + delays[b][1];
      z2 = x * coefs[b][cbeq_pkg::SLOT_B2] - y * coefs[b][cbeq_pkg::SLOT_A2];
      delays[b][0] = clamp(z1, cbeq_pkg::DELAY_W);
      delays[b][1] = clamp(z2, cbeq_pkg::DELAY_W);
      return y;
    endfunction

    function void note_word(cbeq_pkg::cmd_t cmd, logic [IN_W-1:0] data, logic last);
      longint x;
      eq_result_t r;
      int band, slot;
      band = int'(data[19:16]);
      slot = int'(data[22:20]);
      case (cmd)
        cbeq_pkg::CMD_FILTER: begin
          x = longint'($signed(data[15:0]));
          for (int b = 0; b < NB; b++)
            if (enables[b]) x = band_step(b, x);
          r.sample = 16'(clamp(x, 16));
          r.last = last;
          pending.push_back(r);
        end
        cbeq_pkg::CMD_COEF: begin
          if (band < NB && slot < cbeq_pkg::NUM_SLOTS)
            coefs[band][slot] = longint'($signed(data[54:23]));
        end
        cbeq_pkg::CMD_CLEAR: begin
          for (int b = 0; b < NB; b++) begin
            delays[b][0] = 0;
            delays[b][1] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(logic [OUT_W-1:0] data, logic last);
      eq_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output %h", data));
        return;
      end
      e = pending.pop_front();
      if (data !== e.sample)
        report($sformatf("sample_out got %h want %h", data, e.sample));
      if (last !== e.last)
        report($sformatf("block_end got %b want %b", last, e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;  // sample_in, band_index, coef_index, coef_value, pad
  logic [1:0] in_tuser = cbeq_pkg::CMD_FILTER; // command
  logic in_tlast = 0;              // end_of_block
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;     // sample_out
  logic out_tlast;                 // block_end
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [cbeq_pkg::EN_W-1:0] cfg_data = '0;

  eq_scoreboard sb = new();
  bit stall_free;  // phases with no random gaps on either stream

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  cascaded_biquad_equalizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Output side: random ready stalls, check on every handshake
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        gap = stall_free ? 0 : $urandom_range(0, 15);
        out_tready <= (gap == 0);
        if (gap != 0) begin
          repeat (gap - 1) @(posedge clk);
          @(posedge clk);
          out_tready <= 1'b1;
        end
        @(posedge clk iff (out_tvalid && out_tready));
        out_tready <= 1'b0;
      end
    end
  end

  // Send one input word; the model sees it when the handshake lands
  task send_word(cbeq_pkg::cmd_t cmd, logic [IN_W-1:0] data, logic last);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
    end
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    in_tlast <= last;
    @(posedge clk iff in_tready);
    sb.note_word(cmd, data, last);
    in_tvalid <= 1'b0;
  endtask

  function logic [IN_W-1:0] pack(logic [15:0] s, logic [3:0] b, logic [2:0] c,
                                 logic [31:0] v);
    return {1'b0, v, c, b, s};
  endfunction

  task filter(logic [15:0] s, logic last);
    send_word(cbeq_pkg::CMD_FILTER, pack(s, 4'($urandom), 3'($urandom), $urandom), last);
  endtask

  task write_coef(int b, int c, logic [31:0] v);
    send_word(cbeq_pkg::CMD_COEF, pack(16'($urandom), 4'(b), 3'(c), v),
              1'($urandom_range(0, 1)));
  endtask

  // Drain outputs, let the block settle, then write band_enable
  task set_enables(logic [cbeq_pkg::EN_W-1:0] val);
    wait (sb.pending.size() == 0);
    repeat (500) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    sb.enables = val;
  endtask

  // Moderate random coefficient: small so the cascade stays mostly in range,
  // occasionally full-scale to hit the saturation paths
  function logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
  endfunction

  task random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70)
        filter(16'($urandom), 1'($urandom_range(0, 1)));
      else if (k < 88)
        write_coef($urandom_range(0, NB - 1), $urandom_range(0, 4), rand_coef());
      else if (k < 93)
        send_word(cbeq_pkg::CMD_CLEAR, IN_W'($urandom), 1'($urandom_range(0, 1)));
      else if (k < 96)
        write_coef($urandom_range(0, 15), $urandom_range(0, 7), $urandom);
      else
        send_word(cbeq_pkg::CMD_NONE, IN_W'({$urandom, $urandom}),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb.clear_all();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes through pass-through bands
    filter(16'h7FFF, 1'b1);
    filter(16'h8000, 1'b0);
    filter(16'h0000, 1'b1);
    filter(16'hFFFF, 1'b0);
    // gain just under 8 in band 0 drives the output into saturation
    write_coef(0, cbeq_pkg::SLOT_B0, 32'h7FFF_FFFF);
    filter(16'h4000, 1'b0);
    filter(16'hC000, 1'b1);
    write_coef(0, cbeq_pkg::SLOT_B0, 32'h8000_0000);
    write_coef(3, cbeq_pkg::SLOT_B1, 32'h0800_0000);
    write_coef(3, cbeq_pkg::SLOT_A1, 32'hF800_0000);
    write_coef(3, cbeq_pkg::SLOT_B2, 32'h0400_0000);
    write_coef(3, cbeq_pkg::SLOT_A2, 32'h0200_0000);
    filter(16'h1234, 1'b0);
    filter(16'h8000, 1'b1);
    // out of range band and slot: ignored
    write_coef(12, cbeq_pkg::SLOT_B0, 32'h0);
    write_coef(15, cbeq_pkg::SLOT_A2, 32'h0);
    write_coef(2, 5, 32'h0);
    write_coef(2, 7, 32'h0);
    send_word(cbeq_pkg::CMD_NONE, '1, 1'b1);
    filter(16'h0100, 1'b0);
    send_word(cbeq_pkg::CMD_CLEAR, '0, 1'b0);
    filter(16'h7FFF, 1'b1);

    set_enables('0);
    filter(16'h8001, 1'b1);
    set_enables(10'h3FF);
    random_phase(300);
    set_enables(10'h001);
    stall_free = 1;
    random_phase(300);
    stall_free = 0;
    set_enables(10'h200);
    random_phase(300);
    set_enables(10'h2A5);
    random_phase(350);
    set_enables(10'h3FF);
    random_phase(350);

    wait (sb.pending.size() == 0);
    repeat (1000) @(posedge clk);
    if (sb.errors == 0)
      $display("[cascaded_biquad_equalizer] OK");
    else
      $display("[cascaded_biquad_equalizer] ERROR");
    $finish;
  end

  // watchdog for ~1600 words with random gaps and stalls: reports ERROR if the run hangs
  initial begin
    #50_000_000;
    $display("[cascaded_biquad_equalizer] ERROR");
    $finish;
  end

endmodule
